>>> rtl/core/mq_pkg.sv
package mq_pkg;

    localparam int unsigned MQ_DEPTH = 1024;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_ENQ = 2'd0,
        KIND_DEQ = 2'd1,
        KIND_MAX = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // contents of one queue cell
    typedef struct packed {
        logic                     occupied;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] run_max;
    } cell_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [DATA_W-1:0] data;
    } cell_ctrl_t;

endpackage

>>> rtl/core/mq_cell.sv
module mq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mq_pkg::cell_ctrl_t ctrl,
    input  logic               prev_occupied,
    input  mq_pkg::cell_t      from_next,
    output mq_pkg::cell_t      cur
);

    logic                             occupied_reg;
    logic                             occupied_next;
    logic signed [mq_pkg::DATA_W-1:0] value_reg;
    logic signed [mq_pkg::DATA_W-1:0] value_next;
    logic signed [mq_pkg::DATA_W-1:0] run_max_reg;
    logic signed [mq_pkg::DATA_W-1:0] run_max_next;
    logic                             take_new;

    // first free cell takes the new entry
    assign take_new = ctrl.enq & ~occupied_reg & prev_occupied;

    always_comb
    begin
        occupied_next = occupied_reg;
        value_next    = value_reg;
        run_max_next  = run_max_reg;
        if (ctrl.deq)
        begin
            // whole row shifts one cell toward the head
            occupied_next = from_next.occupied;
            value_next    = from_next.value;
            run_max_next  = from_next.run_max;
        end
        else if (take_new)
        begin
            occupied_next = 1'b1;
            value_next    = ctrl.data;
            run_max_next  = ctrl.data;
        end
        else if (ctrl.enq && occupied_reg && ($signed(run_max_reg) < $signed(ctrl.data)))
        begin
            run_max_next = ctrl.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        run_max_reg <= run_max_next;
    end

    assign cur.occupied = occupied_reg;
    assign cur.value    = value_reg;
    assign cur.run_max  = run_max_reg;

endmodule

>>> rtl/core/max_queue.sv
// max_queue: fifo of signed 32-bit values that also reports the maximum it holds
// input channel: in_valid/in_ready with kind (enqueue, dequeue, max query) and value
// output channel: out_valid/out_ready with result_value and status
// a dequeue, a max query, or an enqueue into a full queue gives one result;
// a successful enqueue and the unused kind code give none
// the queue is a row of 1024 cells, head in cell 0; a dequeue shifts the row by
// one cell, an enqueue fills the first free cell and raises every held running
// maximum below the new value
// latency: a result appears on the output register the cycle after its request
// throughput: one request per cycle while results are taken as they appear
// when the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken; a request is taken in the same cycle
// the waiting result leaves
// reset empties the queue (cell occupancy bits clear at once) and drops any
// pending result; the block is ready as soon as reset is released
module max_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       kind,
    input  logic signed [mq_pkg::DATA_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [mq_pkg::DATA_W-1:0] result_value,
    output logic [1:0]                       status
);

    mq_pkg::cell_t      cells [mq_pkg::MQ_DEPTH];
    mq_pkg::cell_ctrl_t ctrl;
    mq_pkg::kind_t      kind_in;
    logic               accept;
    logic               empty;
    logic               full;
    logic               res_fire;
    logic signed [mq_pkg::DATA_W-1:0] res_value;
    mq_pkg::status_t    res_status;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic signed [mq_pkg::DATA_W-1:0] result_value_reg;
    logic signed [mq_pkg::DATA_W-1:0] result_value_next;
    mq_pkg::status_t                  status_reg;
    mq_pkg::status_t                  status_next;

    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;
    assign kind_in  = mq_pkg::kind_t'(kind);
    assign empty    = ~cells[0].occupied;
    assign full     = cells[mq_pkg::MQ_DEPTH-1].occupied;

    always_comb
    begin
        ctrl.enq   = 1'b0;
        ctrl.deq   = 1'b0;
        ctrl.data  = value;
        res_fire   = 1'b0;
        res_value  = '0;
        res_status = mq_pkg::ST_OK;
        case (kind_in)
            mq_pkg::KIND_ENQ:
            begin
                if (full)
                begin
                    res_fire   = accept;
                    res_status = mq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.enq = accept;
                end
            end
            mq_pkg::KIND_DEQ:
            begin
                res_fire = accept;
                if (empty)
                begin
                    res_status = mq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.deq  = accept;
                    res_value = cells[0].value;
                end
            end
            mq_pkg::KIND_MAX:
            begin
                res_fire = accept;
                if (empty)
                begin
                    res_status = mq_pkg::ST_EMPTY;
                end
                else
                begin
                    res_value = cells[0].run_max;
                end
            end
            default:
            begin
                res_fire = 1'b0;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < mq_pkg::MQ_DEPTH; i++)
        begin : g_cell
            mq_pkg::cell_t nbr;
            logic          prev_occ;

            if (i == mq_pkg::MQ_DEPTH - 1)
            begin : g_last
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = cells[i+1];
            end

            if (i == 0)
            begin : g_head
                assign prev_occ = 1'b1;
            end
            else
            begin : g_body
                assign prev_occ = cells[i-1].occupied;
            end

            mq_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .prev_occupied (prev_occ),
                .from_next     (nbr),
                .cur           (cells[i])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        result_value_next = result_value_reg;
        status_next       = status_reg;
        if (res_fire)
        begin
            out_valid_next    = 1'b1;
            result_value_next = res_value;
            status_next       = res_status;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_value_reg <= result_value_next;
        status_reg       <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

endmodule

>>> rtl/core/mq_checker.sv
module mq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [1:0]                       kind,
    input logic signed [mq_pkg::DATA_W-1:0] value,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [mq_pkg::DATA_W-1:0] result_value,
    input logic [1:0]                       status
);

    logic in_acc;

    assign in_acc = in_valid & in_ready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
        else $error("result changed while stalled");

    // no waiting result means the input side is open
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with output empty");

    a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != mq_pkg::ST_OK |-> result_value == '0)
        else $error("nonzero value on error status");

    // a stored enqueue followed by a query reports at least that value
    a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind == mq_pkg::KIND_ENQ) ##1
        (!out_valid && in_acc && kind == mq_pkg::KIND_MAX)
        |=> out_valid && status == mq_pkg::ST_OK && result_value >= $past(value, 2))
        else $error("maximum below a just stored value");

    // a stored enqueue followed by a dequeue cannot see an empty queue
    a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind == mq_pkg::KIND_ENQ) ##1
        (!out_valid && in_acc && kind == mq_pkg::KIND_DEQ)
        |=> out_valid && status == mq_pkg::ST_OK)
        else $error("dequeue reported empty after a stored enqueue");

endmodule

bind max_queue mq_checker u_mq_checker (.*);
